// ===== hdl/trn_pkg.sv =====
// Shared widths, character codes and register indexes for the text number rescaler.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package trn_pkg;

   localparam int VALUE_BITS = 16;
   localparam int SIZE_BITS  = 12;
   localparam int CHAR_BITS  = 8;
   localparam int PROD_BITS  = VALUE_BITS + SIZE_BITS;
   // decimal digits needed for the largest product (floor(n * log10(2)) + 1)
   localparam int NUM_DIGITS = (PROD_BITS * 30103) / 100000 + 1;
   localparam int BCD_BITS   = NUM_DIGITS * 4;
   localparam int ITER_BITS  = $clog2(PROD_BITS + 1);
   localparam int DLEFT_BITS = $clog2(NUM_DIGITS + 1);
   localparam int CSR_IDX_BITS = 2;

   localparam logic [VALUE_BITS-1:0] ACC_MAX = '1;

   localparam logic [CHAR_BITS-1:0] CHAR_ZERO = 8'h30;
   localparam logic [CHAR_BITS-1:0] CHAR_NINE = 8'h39;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_DEST_WIDTH    = 2'd0,
      CSR_SOURCE_WIDTH  = 2'd1,
      CSR_DEST_HEIGHT   = 2'd2,
      CSR_SOURCE_HEIGHT = 2'd3
   } csr_index_type;

endpackage

`default_nettype wire

// ===== hdl/trn_ifs.sv =====
// Valid/ready channel interfaces for the rescaler: request (characters in)
// and response (characters out). Depends on trn_pkg.
`default_nettype none

interface trn_req_if
   import trn_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [CHAR_BITS-1:0] char_in;
   logic                 axis;
   logic                 value_end;

   modport source (output valid, output char_in, output axis, output value_end,
                   input ready);
   modport sink   (input valid, input char_in, input axis, input value_end,
                   output ready);
endinterface

interface trn_rsp_if
   import trn_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [CHAR_BITS-1:0] char_out;
   logic                 run_last;
   logic                 value_done;

   modport source (output valid, output char_out, output run_last, output value_done,
                   input ready);
   modport sink   (input valid, input char_out, input run_last, input value_done,
                   output ready);
endinterface

`default_nettype wire

// ===== hdl/trn_divider.sv =====
// Restoring divider, one quotient bit per cycle, with half-up rounding.
// Depends on trn_pkg.
`default_nettype none

module trn_divider
   import trn_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [PROD_BITS-1:0] dividend,
   input  wire logic [SIZE_BITS-1:0] divisor,
   output logic                      done,
   output logic [PROD_BITS-1:0]      quotient
);

   typedef enum logic [1:0] {
      D_IDLE,
      D_RUN,
      D_ROUND
   } div_state_type;

   div_state_type        state_ff;
   logic [ITER_BITS-1:0] iter_ff;
   logic [PROD_BITS-1:0] work_ff;
   logic [SIZE_BITS-1:0] rem_ff;
   logic [SIZE_BITS-1:0] den_ff;
   logic [PROD_BITS-1:0] quo_ff;
   logic                 done_ff;

   logic [SIZE_BITS:0]   rem_shift;
   logic [SIZE_BITS:0]   diff;
   logic                 fits;
   logic                 round_up;

   always_comb begin
      rem_shift = {rem_ff, work_ff[PROD_BITS-1]};
      fits      = rem_shift >= {1'b0, den_ff};
      diff      = rem_shift - {1'b0, den_ff};
      round_up  = {rem_ff, 1'b0} >= {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
         iter_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            D_IDLE: begin
               if (start) begin
                  work_ff  <= dividend;
                  rem_ff   <= '0;
                  // a zero divisor acts as one
                  den_ff   <= (divisor == '0) ? SIZE_BITS'(1) : divisor;
                  iter_ff  <= '0;
                  state_ff <= D_RUN;
               end
            end
            D_RUN: begin
               rem_ff  <= fits ? diff[SIZE_BITS-1:0] : rem_shift[SIZE_BITS-1:0];
               work_ff <= {work_ff[PROD_BITS-2:0], fits};
               iter_ff <= iter_ff + ITER_BITS'(1);
               if (iter_ff == ITER_BITS'(PROD_BITS - 1)) begin
                  state_ff <= D_ROUND;
               end
            end
            D_ROUND: begin
               quo_ff   <= work_ff + PROD_BITS'(round_up);
               done_ff  <= 1'b1;
               state_ff <= D_IDLE;
            end
            default: state_ff <= D_IDLE;
         endcase
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ===== hdl/trn_bcd.sv =====
// Binary to packed decimal converter, shift-and-add-3, one bit per cycle.
// Depends on trn_pkg.
`default_nettype none

module trn_bcd
   import trn_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [PROD_BITS-1:0] value,
   output logic                      done,
   output logic [BCD_BITS-1:0]       bcd
);

   typedef enum logic {
      B_IDLE,
      B_RUN
   } bcd_state_type;

   bcd_state_type        state_ff;
   logic [ITER_BITS-1:0] iter_ff;
   logic [PROD_BITS-1:0] bin_ff;
   logic [BCD_BITS-1:0]  bcd_ff;
   logic                 done_ff;
   logic [BCD_BITS-1:0]  adj;

   always_comb begin
      adj = bcd_ff;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (bcd_ff[i*4 +: 4] >= 4'd5) begin
            adj[i*4 +: 4] = bcd_ff[i*4 +: 4] + 4'd3;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         done_ff  <= 1'b0;
         iter_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            B_IDLE: begin
               if (start) begin
                  bin_ff   <= value;
                  bcd_ff   <= '0;
                  iter_ff  <= '0;
                  state_ff <= B_RUN;
               end
            end
            B_RUN: begin
               bcd_ff  <= {adj[BCD_BITS-2:0], bin_ff[PROD_BITS-1]};
               bin_ff  <= {bin_ff[PROD_BITS-2:0], 1'b0};
               iter_ff <= iter_ff + ITER_BITS'(1);
               if (iter_ff == ITER_BITS'(PROD_BITS - 1)) begin
                  done_ff  <= 1'b1;
                  state_ff <= B_IDLE;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

   assign done = done_ff;
   assign bcd  = bcd_ff;

endmodule

`default_nettype wire

// ===== hdl/text_number_rescaler_unit.sv =====
// Text number rescaler: digit runs in a character stream become round(n * dest / source).
// A digit without end mark is accepted and added to the pending number. A plain character is
// accepted, then loaded as a response word. A flush steps through accept, multiply, divide,
// decimal conversion, zero skip and digit loads, then a trailing char if any; the response
// side can stall it. The divider and decimal converter are bit-serial; one item is in work
// at a time. Synchronous active-high reset clears the sequencer, pending number and scale
// registers (to 1).
`default_nettype none

module text_number_rescaler_unit
   import trn_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   trn_req_if.sink                      req_bus,
   trn_rsp_if.source                    rsp_bus,
   input  wire logic                    csr_wr_en,
   input  wire logic [CSR_IDX_BITS-1:0] csr_index,
   input  wire logic [SIZE_BITS-1:0]    csr_wdata
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_DIV,
      S_BCD,
      S_SKIP,
      S_EMIT,
      S_CHAR
   } seq_state_type;

   // scale registers
   logic [SIZE_BITS-1:0] dest_width_ff;
   logic [SIZE_BITS-1:0] source_width_ff;
   logic [SIZE_BITS-1:0] dest_height_ff;
   logic [SIZE_BITS-1:0] source_height_ff;

   seq_state_type         state_ff;
   logic [VALUE_BITS-1:0] accum_ff;
   logic                  have_digits_ff;
   logic [CHAR_BITS-1:0]  char_ff;
   logic                  axis_ff;
   logic                  end_ff;
   logic                  is_char_ff;
   logic [PROD_BITS-1:0]  prod_ff;
   logic [SIZE_BITS-1:0]  den_ff;
   logic                  div_start_ff;
   logic                  bcd_start_ff;
   logic [BCD_BITS-1:0]   digits_ff;
   logic [DLEFT_BITS-1:0] digits_left_ff;

   // response word register
   logic                  rsp_valid_ff;
   logic [CHAR_BITS-1:0]  rsp_char_ff;
   logic                  rsp_last_ff;
   logic                  rsp_done_ff;

   logic                  accept;
   logic                  is_digit;
   logic [VALUE_BITS+3:0] accum_next;
   logic [VALUE_BITS-1:0] accum_in;
   logic                  out_free;
   logic [3:0]            top_digit;
   logic                  last_digit;
   logic                  div_done;
   logic [PROD_BITS-1:0]  quotient;
   logic                  bcd_done;
   logic [BCD_BITS-1:0]   bcd;

   assign accept   = req_bus.valid && req_bus.ready;
   assign is_digit = (req_bus.char_in >= CHAR_ZERO) && (req_bus.char_in <= CHAR_NINE);

   // accumulate a digit, saturating at the top of the value range
   always_comb begin
      accum_next = (VALUE_BITS+4)'(accum_ff) * (VALUE_BITS+4)'(10)
                 + (VALUE_BITS+4)'(req_bus.char_in - CHAR_ZERO);
      accum_in   = (accum_next > (VALUE_BITS+4)'(ACC_MAX)) ? ACC_MAX
                                                           : accum_next[VALUE_BITS-1:0];
   end

   assign out_free   = !rsp_valid_ff || rsp_bus.ready;
   assign top_digit  = digits_ff[BCD_BITS-1 -: 4];
   assign last_digit = digits_left_ff == DLEFT_BITS'(1);

   // write scale registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dest_width_ff    <= SIZE_BITS'(1);
         source_width_ff  <= SIZE_BITS'(1);
         dest_height_ff   <= SIZE_BITS'(1);
         source_height_ff <= SIZE_BITS'(1);
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_DEST_WIDTH:    dest_width_ff    <= csr_wdata;
            CSR_SOURCE_WIDTH:  source_width_ff  <= csr_wdata;
            CSR_DEST_HEIGHT:   dest_height_ff   <= csr_wdata;
            CSR_SOURCE_HEIGHT: source_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         accum_ff       <= '0;
         have_digits_ff <= 1'b0;
         div_start_ff   <= 1'b0;
         bcd_start_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         digits_left_ff <= '0;
      end else begin
         div_start_ff <= 1'b0;
         bcd_start_ff <= 1'b0;
         // drop the word once taken; a load below overrides
         if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  char_ff    <= req_bus.char_in;
                  axis_ff    <= req_bus.axis;
                  end_ff     <= req_bus.value_end;
                  is_char_ff <= !is_digit;
                  if (is_digit) begin
                     accum_ff       <= accum_in;
                     have_digits_ff <= 1'b1;
                     if (req_bus.value_end) begin
                        state_ff <= S_MUL;
                     end
                  end else if (have_digits_ff) begin
                     state_ff <= S_MUL;
                  end else begin
                     state_ff <= S_CHAR;
                  end
               end
            end
            S_MUL: begin
               // pick the pair by axis, form the product, and clear the run
               prod_ff        <= PROD_BITS'(accum_ff)
                               * PROD_BITS'(axis_ff ? dest_height_ff : dest_width_ff);
               den_ff         <= axis_ff ? source_height_ff : source_width_ff;
               div_start_ff   <= 1'b1;
               accum_ff       <= '0;
               have_digits_ff <= 1'b0;
               state_ff       <= S_DIV;
            end
            S_DIV: begin
               if (div_done) begin
                  bcd_start_ff <= 1'b1;
                  state_ff     <= S_BCD;
               end
            end
            S_BCD: begin
               if (bcd_done) begin
                  digits_ff      <= bcd;
                  digits_left_ff <= DLEFT_BITS'(NUM_DIGITS);
                  state_ff       <= S_SKIP;
               end
            end
            S_SKIP: begin
               // shift out leading zeros, keep at least one digit
               if (top_digit == 4'd0 && !last_digit) begin
                  digits_ff      <= {digits_ff[BCD_BITS-5:0], 4'd0};
                  digits_left_ff <= digits_left_ff - DLEFT_BITS'(1);
               end else begin
                  state_ff <= S_EMIT;
               end
            end
            S_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_char_ff    <= CHAR_ZERO + CHAR_BITS'(top_digit);
                  rsp_last_ff    <= last_digit && !is_char_ff;
                  rsp_done_ff    <= last_digit && !is_char_ff && end_ff;
                  digits_ff      <= {digits_ff[BCD_BITS-5:0], 4'd0};
                  digits_left_ff <= digits_left_ff - DLEFT_BITS'(1);
                  if (last_digit) begin
                     state_ff <= is_char_ff ? S_CHAR : S_IDLE;
                  end
               end
            end
            S_CHAR: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_char_ff  <= char_ff;
                  rsp_last_ff  <= 1'b1;
                  rsp_done_ff  <= end_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   trn_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (prod_ff),
      .divisor  (den_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   trn_bcd u_bcd (
      .clock (clock),
      .reset (reset),
      .start (bcd_start_ff),
      .value (quotient),
      .done  (bcd_done),
      .bcd   (bcd)
   );

   assign req_bus.ready      = state_ff == S_IDLE;
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.char_out   = rsp_char_ff;
   assign rsp_bus.run_last   = rsp_last_ff;
   assign rsp_bus.value_done = rsp_done_ff;

   // the divider only finishes while the sequencer waits on it
   assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIV)
      else $error("divider done outside divide wait");

   // the decimal converter only finishes while the sequencer waits on it
   assert property (@(posedge clock) disable iff (reset)
      bcd_done |-> state_ff == S_BCD)
      else $error("converter done outside convert wait");

   // a non-digit with nothing pending goes straight to passing the character
   assert property (@(posedge clock) disable iff (reset)
      accept && !is_digit && !have_digits_ff |=> state_ff == S_CHAR)
      else $error("plain character did not bypass the flush");

   // starting a flush always clears the pending run
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MUL |=> !have_digits_ff && accum_ff == '0)
      else $error("pending run not cleared by flush");

   // digit emission never runs with an empty digit count
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EMIT |-> digits_left_ff != '0)
      else $error("emitting with no digits left");

endmodule

`default_nettype wire

// ===== tb/text_number_rescaler_unit_tb.sv =====
// Self-checking testbench for text_number_rescaler_unit: streams character words in,
// predicts the rescaled text and compares each response word in order.
// Depends on trn_pkg and on the trn_req_if / trn_rsp_if interfaces.

module text_number_rescaler_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import trn_pkg::*;

   localparam int IDLE_PCT       = 9;     // chance in a hundred of an idle cycle per side
   localparam int HOLD_CYCLES    = 300;   // long response back-pressure stretch
   localparam int SETTLE_CYCLES  = 2 * PROD_BITS + NUM_DIGITS + 20;
   localparam int WATCHDOG_LIMIT = 2000;  // cycles without any handshake
   localparam int RANDOM_WORDS   = 90;

   typedef struct packed {
      logic [CHAR_BITS-1:0] char_out;
      logic                 run_last;
      logic                 value_done;
   } out_word_t;

   // Holds the rescaler state (scale registers, pending digit run) and the
   // queue of response words still owed by the block.
   class rescale_scoreboard;
      logic [SIZE_BITS-1:0]  scale_reg [4];
      logic [VALUE_BITS-1:0] digit_sum;
      bit                    number_open;
      out_word_t             owed_q [$];
      int                    errors;

      function new();
         foreach (scale_reg[i]) scale_reg[i] = SIZE_BITS'(1);
         digit_sum   = '0;
         number_open = 1'b0;
         errors      = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [SIZE_BITS-1:0] val);
         scale_reg[int'(idx)] = val;
      endfunction

      function int pending();
         return owed_q.size();
      endfunction

      // Emit round-half-up(digit_sum * dest / source) as decimal text.
      function void flush_number(logic ax);
         longint unsigned numer, denom, prod, quo;
         byte unsigned    digits [$];
         out_word_t       w;
         if (!number_open) return;
         numer = ax ? scale_reg[int'(CSR_DEST_HEIGHT)]   : scale_reg[int'(CSR_DEST_WIDTH)];
         denom = ax ? scale_reg[int'(CSR_SOURCE_HEIGHT)] : scale_reg[int'(CSR_SOURCE_WIDTH)];
         if (denom == 0) denom = 1;
         prod = longint'(digit_sum) * numer;
         quo  = prod / denom;
         if (2 * (prod % denom) >= denom) quo++;
         do begin
            digits.push_front(8'(CHAR_ZERO + quo % 10));
            quo = quo / 10;
         end while (quo != 0);
         foreach (digits[i]) begin
            w.char_out   = digits[i];
            w.run_last   = 1'b0;
            w.value_done = 1'b0;
            owed_q.push_back(w);
         end
         digit_sum   = '0;
         number_open = 1'b0;
      endfunction

      function void note_word(logic [CHAR_BITS-1:0] ch, logic ax, logic vend);
         int unsigned grown;
         int          n_prior;
         out_word_t   w;
         n_prior = owed_q.size();
         if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
            grown       = digit_sum * 10 + (ch - CHAR_ZERO);
            digit_sum   = (grown > ACC_MAX) ? ACC_MAX : grown[VALUE_BITS-1:0];
            number_open = 1'b1;
            if (vend) flush_number(ax);
         end else begin
            flush_number(ax);
            w.char_out   = ch;
            w.run_last   = 1'b0;
            w.value_done = 1'b0;
            owed_q.push_back(w);
         end
         if (owed_q.size() > n_prior) begin
            owed_q[owed_q.size() - 1].run_last   = 1'b1;
            owed_q[owed_q.size() - 1].value_done = vend;
         end
      endfunction

      task report(string what);
         errors++;
         $display("MISMATCH at %0t ns: %s", $time, what);
      endtask

      task check_word(out_word_t got);
         out_word_t want;
         if (owed_q.size() == 0) begin
            report($sformatf("unexpected word char_out=%h", got.char_out));
            return;
         end
         want = owed_q.pop_front();
         if (got.char_out !== want.char_out)
            report($sformatf("char_out %h, want %h", got.char_out, want.char_out));
         if (got.run_last !== want.run_last)
            report($sformatf("run_last %b, want %b (char %h)", got.run_last, want.run_last,
                             want.char_out));
         if (got.value_done !== want.value_done)
            report($sformatf("value_done %b, want %b (char %h)", got.value_done,
                             want.value_done, want.char_out));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;
   logic                    csr_wr_en;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic [SIZE_BITS-1:0]    csr_wdata;

   trn_req_if req_if ();
   trn_rsp_if rsp_if ();

   rescale_scoreboard sb;
   bit no_idle  = 1'b0;   // both sides run without idle cycles while set
   bit hold_rsp = 1'b0;   // request a long back-pressure stretch on the response side
   int sent_words  = 0;
   int idle_cycles = 0;

   text_number_rescaler_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_if.sink),
      .rsp_bus   (rsp_if.source),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   // Monitor both channels at the edge; note the input word before checking
   // the output so a same-edge pair is handled in stream order.
   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready)
         sb.note_word(req_if.char_in, req_if.axis, req_if.value_end);
      if (!reset && rsp_if.valid && rsp_if.ready)
         sb.check_word({rsp_if.char_out, rsp_if.run_last, rsp_if.value_done});
   end

   // Watchdog: count cycles with no handshake on either channel.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Response side: random ready, or a long hold-off when requested, counted here.
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else begin
            rsp_if.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // Offer one word, with an optional idle gap first; return at the accepting edge
   // with valid still high so the next word can follow back to back.
   task automatic send_word(logic [CHAR_BITS-1:0] ch, logic ax, logic vend);
      if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.char_in   <= ch;
      req_if.axis      <= ax;
      req_if.value_end <= vend;
      do @(posedge clock); while (!req_if.ready);
      sent_words++;
   endtask

   // Drop valid at the current edge; call only right after an accepted word.
   task automatic release_req();
      req_if.valid <= 1'b0;
   endtask

   // Let at least one edge pass, then hold until nothing is owed.
   task automatic wait_drained();
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // Send a string; the end mark goes on its last character when asked.
   task automatic send_text(string s, logic ax, logic end_last);
      int i;
      for (i = 0; i < s.len(); i++)
         send_word(s[i], ax, end_last && (i == s.len() - 1));
   endtask

   task automatic write_reg(csr_index_type idx, logic [SIZE_BITS-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      sb.write_reg(idx, val);
      @(posedge clock);
   endtask

   // Reprogram all four scale registers once the block is quiet. A digit without
   // end mark owes nothing, so also wait out a full flush after the queue empties.
   task automatic set_scale(logic [SIZE_BITS-1:0] dw, logic [SIZE_BITS-1:0] sw,
                            logic [SIZE_BITS-1:0] dh, logic [SIZE_BITS-1:0] sh);
      release_req();
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_reg(CSR_DEST_WIDTH, dw);
      write_reg(CSR_SOURCE_WIDTH, sw);
      write_reg(CSR_DEST_HEIGHT, dh);
      write_reg(CSR_SOURCE_HEIGHT, sh);
      csr_wr_en <= 1'b0;
   endtask

   // Favor the extremes, zero included, so the zero divisor case recurs.
   function automatic logic [SIZE_BITS-1:0] pick_size();
      int r;
      r = $urandom_range(99);
      if (r < 10)      return '0;
      else if (r < 25) return '1;
      else if (r < 35) return SIZE_BITS'(1);
      else             return SIZE_BITS'($urandom_range((1 << SIZE_BITS) - 1, 1));
   endfunction

   function automatic logic [CHAR_BITS-1:0] pick_non_digit();
      logic [CHAR_BITS-1:0] c;
      do c = CHAR_BITS'($urandom_range(255)); while (c >= CHAR_ZERO && c <= CHAR_NINE);
      return c;
   endfunction

   // One random value: mostly a digit run closed by an end mark, a separator or
   // both; a few raw noise bytes and runs with the axis changing mid-run.
   task automatic send_random_value();
      int   n_dig, term, kind, i;
      logic ax;
      ax   = 1'($urandom_range(1));
      kind = $urandom_range(99);
      if (kind < 12) begin
         repeat ($urandom_range(3, 1))
            send_word(CHAR_BITS'($urandom_range(255)), 1'($urandom_range(1)),
                      1'($urandom_range(1)));
      end else begin
         // mostly short runs; some long ones drive the accumulator into saturation
         n_dig = ($urandom_range(99) < 10) ? $urandom_range(10, 6) : $urandom_range(5, 1);
         term  = $urandom_range(2);
         for (i = 0; i < n_dig; i++)
            send_word(CHAR_BITS'(CHAR_ZERO + $urandom_range(9)),
                      (kind < 20) ? 1'($urandom_range(1)) : ax,
                      (term == 0) && (i == n_dig - 1));
         if (term != 0)
            send_word(pick_non_digit(), ax, term == 2);
      end
   endtask

   task automatic random_phase(int words);
      int stop_at;
      stop_at = sent_words + words;
      while (sent_words < stop_at) send_random_value();
   endtask

   initial begin
      sb = new();
      reset            <= 1'b1;
      req_if.valid     <= 1'b0;
      req_if.char_in   <= '0;
      req_if.axis      <= 1'b0;
      req_if.value_end <= 1'b0;
      csr_wr_en        <= 1'b0;
      csr_index        <= CSR_DEST_WIDTH;
      csr_wdata        <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Reset scale (all ones): zero, leading zeros, empty flush, byte extremes,
      // and a run closed by ':' just above the digit range.
      send_text("0", 1'b0, 1'b1);
      send_text("007", 1'b0, 1'b1);
      send_word("x", 1'b0, 1'b1);
      send_word(8'h00, 1'b0, 1'b0);
      send_word(8'hFF, 1'b1, 1'b1);
      send_text("42:", 1'b0, 1'b0);

      // Widest product on the horizontal axis, strongest shrink on the vertical one.
      set_scale(12'd4095, 12'd1, 12'd1, 12'd4095);
      send_text("999999,", 1'b0, 1'b1);   // saturates, then the separator flushes it
      send_text("65535", 1'b1, 1'b1);
      send_text("1", 1'b1, 1'b1);         // rounds down to zero

      // Halves round up; vertical divisor of zero acts as one; '/' sits below '0'.
      set_scale(12'd1, 12'd2, 12'd3, 12'd0);
      send_text("3", 1'b0, 1'b1);
      send_text("1", 1'b0, 1'b1);
      send_text("5", 1'b1, 1'b1);
      send_text("8/", 1'b1, 1'b0);

      // Random phase with no idling on either side.
      set_scale(pick_size(), pick_size(), pick_size(), pick_size());
      no_idle = 1'b1;
      random_phase(RANDOM_WORDS);
      no_idle = 1'b0;

      // Hold the response side off while words keep coming, so the block backs up.
      set_scale(12'd4095, 12'd1, 12'd1, 12'd4095);
      hold_rsp = 1'b1;
      random_phase(RANDOM_WORDS);

      // Pause the sender halfway until every owed word has come out.
      set_scale(pick_size(), pick_size(), pick_size(), pick_size());
      random_phase(RANDOM_WORDS / 2);
      release_req();
      wait_drained();
      random_phase(RANDOM_WORDS / 2);

      set_scale(pick_size(), pick_size(), pick_size(), pick_size());
      random_phase(RANDOM_WORDS);

      // Drain, then give stray words a chance to show up.
      release_req();
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
